>>> design/adr_pkg.sv
// Shared types and constants of the analog dead-band reporter.
package adr_pkg;

    localparam int TIME_W      = 32;
    localparam int SCALE_W     = 12;
    localparam int INTERVAL_W  = 20;
    localparam int DELTA_W     = 7;
    localparam int VALUE_W     = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int PCT_SCALE   = 100;

    // Saturation limits of the signed percent.
    localparam int PCT_MAX_POS = (1 << (VALUE_W - 1)) - 1;
    localparam int PCT_MIN_MAG = 1 << (VALUE_W - 1);

    // Register reset values.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(1000);
    localparam logic [DELTA_W-1:0]    DELTA_RESET     = DELTA_W'(2);
    localparam logic [SCALE_W-1:0]    SCALE_MIN_RESET = SCALE_W'(0);
    localparam logic [SCALE_W-1:0]    SCALE_MAX_RESET = SCALE_W'(4095);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_PERCENT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL       = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA          = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MIN      = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MAX      = CFG_INDEX_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_DECIDE,
        ST_OUT
    } adr_state_t;

    // Handshake between the sequencer and the serial divider.
    typedef struct packed {
        logic start;
    } adr_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } adr_div_stat_t;

endpackage

>>> design/analog_deadband_reporter.sv
// Top level of the analog dead-band reporter: sequencer, datapath and registers.
//
// The block takes one tick request at a time, each carrying a millisecond time
// stamp and a converter sample, and reports the sample (raw mode) or its
// percent of the configured span (percent mode) when the percent has moved by
// at least report_delta since the last report. A tick earlier than the next
// measure time, or one whose raw sample equals the last reported one in raw
// mode, is dropped in the check state: the block returns to idle from there
// and the schedule does not move. Any other tick runs through the full check,
// in which the serial divider produces one quotient bit per cycle over
// MAG_W + 7 steps, where MAG_W is the larger of SAMPLE_BITS and 12. A tick in
// percent mode whose percent equals the last reported one is dropped in the
// decide state, without passing the output state, and leaves the schedule
// alone. A zero span skips the divider. The result sits in an output
// register; if it has not been taken when the next result is due, the
// sequencer waits for it. Configuration is written through a plain write
// port; the user must write it only while the block is idle, which the block
// itself does not enforce; values are masked to their register widths and
// unknown indexes are ignored. The percent is (sample - scale_min) * 100 /
// (scale_max - scale_min), truncated toward zero, 0 for a zero span, and
// saturated to the signed 20-bit output range.
module analog_deadband_reporter
    import adr_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input tick requests.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: now_ms [31:0], adc_sample [SAMPLE_BITS+31:32], zero padding above.
    input  logic [((TIME_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Report requests.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: reported_value [19:0] (two's complement), zero padding above.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IN_TDATA_W = ((TIME_W + SAMPLE_BITS + 7) / 8) * 8;
    localparam int MAG_W      = (SAMPLE_BITS > SCALE_W) ? SAMPLE_BITS : SCALE_W;
    localparam int NUM_W      = MAG_W + 7;
    localparam int EXT_W      = (NUM_W > VALUE_W) ? NUM_W + 1 : VALUE_W + 1;

    // Configuration registers.
    logic                  report_percent_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic [SCALE_W-1:0]    scale_min_reg;
    logic [SCALE_W-1:0]    scale_max_reg;

    // Sequencer and item state.
    adr_state_t state_reg, state_next;

    logic [TIME_W-1:0]        now_reg, now_next;
    logic [SAMPLE_BITS-1:0]   sample_reg, sample_next;
    logic [TIME_W-1:0]        next_time_reg, next_time_next;
    logic signed [SAMPLE_BITS:0] last_sample_reg, last_sample_next;
    logic signed [VALUE_W-1:0]   last_pct_reg, last_pct_next;

    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic                     span_zero_reg, span_zero_next;
    logic [SCALE_W-1:0]       span_mag_reg, span_mag_next;
    logic signed [VALUE_W-1:0] pct_reg, pct_next;
    logic                     report_reg, report_next;

    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]       out_value_reg, out_value_next;

    // Combinational helpers.
    logic                     early;
    logic                     raw_same;
    logic signed [MAG_W:0]    diff;
    logic signed [SCALE_W:0]  span;
    logic [NUM_W-1:0]         num;
    logic [EXT_W-1:0]         q_ext;
    logic signed [VALUE_W:0]  pct_diff;
    logic [VALUE_W:0]         pct_abs;
    logic                     pct_same;
    logic                     out_free;

    adr_div_ctl_t     div_ctl;
    adr_div_stat_t    div_stat;
    logic [NUM_W-1:0] div_quotient;

    adr_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SCALE_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (num),
        .divisor  (span_mag_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // Comparisons used by the sequencer.
    always_comb begin
        early    = (now_reg < next_time_reg);
        raw_same = ({1'b0, sample_reg} == last_sample_reg);
        pct_same = (pct_reg == last_pct_reg);
        out_free = !out_valid_reg || m_tready;
        diff     = $signed({{(MAG_W + 1 - SAMPLE_BITS){1'b0}}, sample_reg})
                 - $signed({{(MAG_W + 1 - SCALE_W){1'b0}}, scale_min_reg});
        span     = $signed({1'b0, scale_max_reg}) - $signed({1'b0, scale_min_reg});
        // The scaled magnitude goes straight into the divider as it starts.
        num      = NUM_W'({7'b0, mag_reg} * NUM_W'(PCT_SCALE));
        q_ext    = EXT_W'(div_quotient);
        pct_diff = {pct_reg[VALUE_W-1], pct_reg} - {last_pct_reg[VALUE_W-1], last_pct_reg};
        pct_abs  = pct_diff[VALUE_W] ? (VALUE_W + 1)'(0) - pct_diff : pct_diff;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (early || (!report_percent_reg && raw_same)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = span_zero_reg ? ST_SAT : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (report_percent_reg && pct_same) ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (!report_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready      = 1'b0;
        div_ctl.start = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready      = 1'b1;
            ST_MUL:  div_ctl.start = !span_zero_reg;
            default: begin
                s_tready      = 1'b0;
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        now_next         = now_reg;
        sample_next      = sample_reg;
        next_time_next   = next_time_reg;
        last_sample_next = last_sample_reg;
        last_pct_next    = last_pct_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        span_zero_next   = span_zero_reg;
        span_mag_next    = span_mag_reg;
        pct_next         = pct_reg;
        report_next      = report_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_value_next   = out_value_reg;

        case (state_reg)
            ST_IDLE: begin
                now_next    = s_tdata[TIME_W-1:0];
                sample_next = s_tdata[TIME_W + SAMPLE_BITS - 1:TIME_W];
            end
            ST_CHECK: begin
                // Magnitudes and the result sign for a truncating division.
                mag_next       = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
                neg_next       = diff[MAG_W] ^ span[SCALE_W];
                span_zero_next = (span == '0);
                span_mag_next  = span[SCALE_W] ? SCALE_W'(-span) : span[SCALE_W-1:0];
            end
            ST_SAT: begin
                if (span_zero_reg) begin
                    pct_next = '0;
                end else if (neg_reg) begin
                    pct_next = (q_ext > EXT_W'(PCT_MIN_MAG))
                             ? VALUE_W'(PCT_MIN_MAG)
                             : VALUE_W'(EXT_W'(0) - q_ext);
                end else begin
                    pct_next = (q_ext > EXT_W'(PCT_MAX_POS))
                             ? VALUE_W'(PCT_MAX_POS)
                             : q_ext[VALUE_W-1:0];
                end
            end
            ST_DECIDE: begin
                if (!(report_percent_reg && pct_same)) begin
                    report_next    = (pct_abs >= (VALUE_W + 1)'(delta_reg));
                    next_time_next = now_reg + TIME_W'(interval_reg);
                    if (pct_abs >= (VALUE_W + 1)'(delta_reg)) begin
                        last_sample_next = {1'b0, sample_reg};
                        last_pct_next    = pct_reg;
                    end
                end
            end
            ST_OUT: begin
                if (report_reg && out_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = report_percent_reg ? pct_reg
                                                        : VALUE_W'(sample_reg);
                end
            end
            default: begin
                out_value_next = out_value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            next_time_reg   <= '0;
            last_sample_reg <= '1;
            last_pct_reg    <= '1;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_time_reg   <= next_time_next;
            last_sample_reg <= last_sample_next;
            last_pct_reg    <= last_pct_next;
            out_valid_reg   <= out_valid_next;
        end
        now_reg       <= now_next;
        sample_reg    <= sample_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        span_zero_reg <= span_zero_next;
        span_mag_reg  <= span_mag_next;
        pct_reg       <= pct_next;
        report_reg    <= report_next;
        out_value_reg <= out_value_next;
    end

    // Configuration registers; the user must write only while idle (not enforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_percent_reg <= 1'b0;
            interval_reg       <= INTERVAL_RESET;
            delta_reg          <= DELTA_RESET;
            scale_min_reg      <= SCALE_MIN_RESET;
            scale_max_reg      <= SCALE_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REPORT_PERCENT: report_percent_reg <= cfg_wdata[0];
                REG_INTERVAL:       interval_reg       <= cfg_wdata[INTERVAL_W-1:0];
                REG_DELTA:          delta_reg          <= cfg_wdata[DELTA_W-1:0];
                REG_SCALE_MIN:      scale_min_reg      <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_MAX:      scale_max_reg      <= cfg_wdata[SCALE_W-1:0];
                default: begin
                    report_percent_reg <= report_percent_reg;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - VALUE_W){1'b0}}, out_value_reg};

endmodule

>>> design/adr_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module adr_divider
    import adr_pkg::*;
#(
    parameter int NUM_W = 19,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  adr_div_ctl_t     ctl,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output adr_div_stat_t    stat,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             trial_ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        trial_ge  = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits DEN_W bits.
            rem_next = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], trial_ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the analog dead-band reporter.
`timescale 1ns / 100ps

module tb;
    import adr_pkg::*;

    // The block runs with its default sample width; the tick request packs
    // now_ms in the low 32 bits and the sample above it, padded to bytes.
    localparam int SAMPLE_W      = 12;
    localparam int S_TDATA_W     = ((TIME_W + SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;

    // Give the block a margin beyond a full check before touching its
    // registers or ending the run.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    // The random part runs through several register settings, and the last
    // one runs with both sides streaming at full rate.
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;

    // Register indexes past the last mapped one must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = REG_SCALE_MAX + 1'b1;

    // Every input of the block starts at a known value.
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // tdata: now_ms [31:0], adc_sample [43:32], zero padding above.
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // tdata: reported_value [19:0], zero padding above.
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Our own copy of the registers, as the block should hold them.
    logic                   cfg_report_percent = 1'b0;
    logic [INTERVAL_W-1:0]  cfg_interval       = INTERVAL_RESET;
    logic [DELTA_W-1:0]     cfg_delta          = DELTA_RESET;
    logic [SCALE_W-1:0]     cfg_scale_min      = SCALE_MIN_RESET;
    logic [SCALE_W-1:0]     cfg_scale_max      = SCALE_MAX_RESET;

    // Our own copy of the schedule and of the last report. Both last values
    // start at minus one, meaning nothing has been reported yet.
    logic [TIME_W-1:0]      next_check_ms = '0;
    int                     last_sample   = -1;
    int                     last_percent  = -1;

    // Values the block owes us, oldest first.
    logic [VALUE_W-1:0]     pending_reports[$];
    logic [VALUE_W-1:0]     want_value;

    bit                     quiet_phase = 1'b0;
    int                     walk_sample = 0;
    int                     n_ticks     = 0;
    int                     n_early     = 0;
    int                     n_unchanged = 0;
    int                     n_checks    = 0;
    int                     n_reports   = 0;
    int                     n_errors    = 0;
    int                     cycle_count = 0;

    analog_deadband_reporter #(
        .SAMPLE_BITS(SAMPLE_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Hard stop in case the block hangs or loses a report.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d reports still owed",
                     cycle_count, pending_reports.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Percent of the configured span, truncated toward zero, zero for an
    // empty span and clamped to the signed output range. The products stay
    // far inside 64 bits, so the division is exact before truncation.
    function automatic logic signed [VALUE_W-1:0] span_percent(
        input logic [SCALE_W-1:0] smp
    );
        longint span;
        longint q;
        span = longint'(cfg_scale_max) - longint'(cfg_scale_min);
        if (span == 0) begin
            return '0;
        end
        q = ((longint'(smp) - longint'(cfg_scale_min)) * PCT_SCALE) / span;
        if (q > PCT_MAX_POS) begin
            q = PCT_MAX_POS;
        end
        if (q < -longint'(PCT_MIN_MAG)) begin
            q = -longint'(PCT_MIN_MAG);
        end
        return VALUE_W'(q);
    endfunction

    // Works out what one accepted tick does to the schedule and to the last
    // report, and queues the value the block must report, if any.
    task automatic predict_report(input logic [TIME_W-1:0] now,
                                  input logic [SAMPLE_W-1:0] smp);
        int     pct;
        longint move;
        // A tick ahead of the schedule is ignored outright.
        if (now < next_check_ms) begin
            n_early++;
            return;
        end
        // Raw mode drops a repeat of the last reported sample; the schedule
        // stays where it is.
        if (!cfg_report_percent && int'(smp) == last_sample) begin
            n_unchanged++;
            return;
        end
        pct = int'(span_percent(smp));
        // Percent mode drops a repeat of the last reported percent. Right
        // after reset that includes a percent of minus one.
        if (cfg_report_percent && pct == last_percent) begin
            n_unchanged++;
            return;
        end
        n_checks++;
        move = longint'(pct) - longint'(last_percent);
        if (move < 0) begin
            move = -move;
        end
        if (move >= longint'(cfg_delta)) begin
            pending_reports.push_back(cfg_report_percent ? VALUE_W'(pct)
                                                         : VALUE_W'(smp));
            last_sample  = int'(smp);
            last_percent = pct;
        end
        // The schedule wraps modulo 2^32 like the time stamp itself.
        next_check_ms = now + TIME_W'(cfg_interval);
    endtask

    // Drives one tick request and holds it until the block takes it. The
    // valid stays high into the next request unless a gap follows, so it is
    // never lowered and raised within one time step.
    task automatic send_tick(input logic [TIME_W-1:0] now,
                             input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({smp, now});
        do @(posedge aclk); while (!s_tready);
        n_ticks++;
        predict_report(now, smp);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // One register write. The enable drops for a cycle afterwards, so that a
    // following write never stacks two assignments in one time step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_REPORT_PERCENT: cfg_report_percent = data[0];
            REG_INTERVAL:       cfg_interval       = data[INTERVAL_W-1:0];
            REG_DELTA:          cfg_delta          = data[DELTA_W-1:0];
            REG_SCALE_MIN:      cfg_scale_min      = data[SCALE_W-1:0];
            REG_SCALE_MAX:      cfg_scale_max      = data[SCALE_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops sending and waits for every owed report. A tick that ends in no
    // report may still be in the divider, so the block is given a settling
    // margin before anyone touches its registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Everything the block reports is compared with the oldest value owed.
    // Padding above the value must read as zero, so the whole word is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: report with none expected: expected nothing, got %0d",
                         $time, $signed(m_tdata[VALUE_W-1:0]));
                n_errors++;
            end else begin
                want_value = pending_reports.pop_front();
                n_reports++;
                if (m_tdata !== OUT_TDATA_W'(want_value)) begin
                    $display("%0t: reported_value mismatch: expected %0d (%h), got %0d (%h)",
                             $time, $signed(want_value), OUT_TDATA_W'(want_value),
                             $signed(m_tdata[VALUE_W-1:0]), m_tdata);
                    n_errors++;
                end
            end
        end
    end

    // The receiver stalls in random bursts between calm stretches, and
    // never in the last phase.
    int stall_left = 0;
    int calm_left  = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (calm_left != 0) begin
                calm_left--;
            end else if (!quiet_phase) begin
                if ($urandom_range(0, 1) == 1) begin
                    calm_left = $urandom_range(10, 80);
                end else begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    // Reset values of the registers: the first check sees percent 0 against
    // a last percent of minus one; the move of one is below the default delta of two.
    task automatic test_reset_defaults();
        send_tick(32'd0, 12'd0);
        send_tick(32'd999, 12'd4095);
        send_tick(32'd1000, 12'd1);
    endtask

    // Percent mode, starting while the last percent still holds its reset
    // value, then an empty span, and spans of one in both directions that
    // give the largest magnitudes a 12-bit sample can reach.
    task automatic test_percent_mode();
        wait_idle();
        write_reg(REG_REPORT_PERCENT, 20'd1);
        write_reg(REG_SCALE_MIN, 20'd100);
        write_reg(REG_SCALE_MAX, 20'd0);
        // Inverted span: one step past the minimum is minus one percent.
        send_tick(32'd2000, 12'd101);
        send_tick(32'd2000, 12'd150);
        wait_idle();
        write_reg(REG_SCALE_MIN, 20'd7);
        write_reg(REG_SCALE_MAX, 20'd7);
        send_tick(32'd3000, 12'd4095);
        send_tick(32'd4000, 12'd0);
        wait_idle();
        write_reg(REG_DELTA, 20'd127);
        write_reg(REG_SCALE_MIN, 20'd0);
        write_reg(REG_SCALE_MAX, 20'd1);
        send_tick(32'd4000, 12'd4095);
        wait_idle();
        write_reg(REG_SCALE_MIN, 20'd1);
        write_reg(REG_SCALE_MAX, 20'd0);
        send_tick(32'd5000, 12'd4095);
        send_tick(32'd6000, 12'd0);
    endtask

    // Raw mode with a delta of zero and no interval: a changed sample on time
    // is reported, a repeat is dropped, and the schedule does not move.
    task automatic test_raw_mode_drops();
        wait_idle();
        // Only bit zero of the mode register counts, so this selects raw.
        write_reg(REG_REPORT_PERCENT, 20'd2);
        // Bit seven is cut off, leaving a delta of zero.
        write_reg(REG_DELTA, 20'd128);
        write_reg(REG_INTERVAL, 20'd0);
        write_reg(REG_SCALE_MIN, 20'd0);
        write_reg(REG_SCALE_MAX, 20'd4095);
        send_tick(32'd7000, 12'd4095);
        send_tick(32'd7000, 12'd4095);
        send_tick(32'd7000, 12'd4094);
        send_tick(32'd6999, 12'd0);
    endtask

    // Writes to unmapped indexes must change nothing, and data wider than a
    // register is cut to its width; the widest interval is used right away.
    task automatic test_register_masking();
        wait_idle();
        for (int idx = REG_UNMAPPED_FIRST; idx < (1 << CFG_INDEX_W); idx++) begin
            write_reg(CFG_INDEX_W'(idx), '1);
        end
        write_reg(REG_REPORT_PERCENT, '1);
        write_reg(REG_INTERVAL, '1);
        write_reg(REG_DELTA, 20'd129);
        write_reg(REG_SCALE_MIN, '1);
        write_reg(REG_SCALE_MAX, 20'd0);
        send_tick(32'd7000, 12'd0);
        send_tick(next_check_ms - 1'b1, 12'd5);
        send_tick(next_check_ms, 12'd2000);
    endtask

    // Time stamps at the top of the 32-bit range, where the next measure
    // time wraps around to a small value.
    task automatic test_time_wrap();
        wait_idle();
        write_reg(REG_REPORT_PERCENT, 20'd0);
        write_reg(REG_INTERVAL, 20'd1000);
        write_reg(REG_DELTA, 20'd2);
        write_reg(REG_SCALE_MIN, 20'd0);
        write_reg(REG_SCALE_MAX, 20'd4095);
        send_tick(32'hFFFF_FFFF, 12'd4000);
        send_tick(next_check_ms - 1'b1, 12'd100);
        send_tick(next_check_ms, 12'd100);
        send_tick(32'd0, 12'd200);
    endtask

    // Random traffic over several register settings. Most ticks land on or
    // just after the schedule with a sample that wanders, so the dead band
    // decides; the rest are early ticks, repeats, jumps and random times.
    task automatic test_random_traffic();
        logic [TIME_W-1:0] now;
        int                pick;
        int                lo;
        int                hi;
        int                counted;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            quiet_phase = (phase == RANDOM_PHASES - 1);
            write_reg(REG_REPORT_PERCENT, CFG_DATA_W'($urandom_range(0, 1)));
            // The first two settings take a small and a large interval and delta.
            case (phase)
                0: begin
                    write_reg(REG_INTERVAL, 20'd1);
                    write_reg(REG_DELTA, 20'd1);
                end
                1: begin
                    write_reg(REG_INTERVAL, 20'd900000);
                    write_reg(REG_DELTA, 20'd100);
                end
                default: begin
                    write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(1, 5000)));
                    write_reg(REG_DELTA, CFG_DATA_W'($urandom_range(1, 30)));
                end
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    lo = 0;
                    hi = SAMPLE_TOP;
                end
                1: begin
                    lo = $urandom_range(0, 2000);
                    hi = lo + $urandom_range(1, 2095);
                end
                2: begin
                    lo = $urandom_range(0, 4000);
                    hi = lo + $urandom_range(1, 8);
                end
                3: begin
                    hi = $urandom_range(0, 2000);
                    lo = hi + $urandom_range(1, 2095);
                end
                default: begin
                    lo = $urandom_range(0, SAMPLE_TOP);
                    hi = lo;
                end
            endcase
            write_reg(REG_SCALE_MIN, CFG_DATA_W'(lo));
            write_reg(REG_SCALE_MAX, CFG_DATA_W'(hi));
            walk_sample = (lo + hi) / 2;

            // Early ticks are only ignored, so they do not count.
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    now = next_check_ms - TIME_W'($urandom_range(1, 1000));
                end else if (pick < 12) begin
                    now = $urandom;
                end else begin
                    now = next_check_ms + TIME_W'($urandom_range(0, 3));
                end
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    walk_sample = $urandom_range(0, SAMPLE_TOP);
                end else if (pick < 23 && last_sample >= 0) begin
                    walk_sample = last_sample;
                end else begin
                    walk_sample += int'($urandom_range(0, 160)) - 80;
                    if (walk_sample < 0) begin
                        walk_sample = 0;
                    end
                    if (walk_sample > SAMPLE_TOP) begin
                        walk_sample = SAMPLE_TOP;
                    end
                end
                if (!(now < next_check_ms)) begin
                    counted++;
                end
                send_tick(now, SAMPLE_W'(walk_sample));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_percent_mode();
        test_raw_mode_drops();
        test_register_masking();
        test_time_wrap();
        test_random_traffic();

        // Drain, then give the block time to show any stray report.
        wait_idle();

        $display("tb: %0d tick requests: %0d early, %0d unchanged, %0d full checks",
                 n_ticks, n_early, n_unchanged, n_checks);
        $display("tb: %0d reports checked over directed extremes and %0d random settings",
                 n_reports, RANDOM_PHASES);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
